// File: rtl/core/euv_pkg.sv
// ----------------------------------------------------------------------------
// euv_pkg
// Shared constants and types for the encoder unwrap / velocity block.
// ----------------------------------------------------------------------------
`default_nettype none
package euv_pkg;
    localparam int HISTORY_DEPTH_DEF = 5;
    localparam int ANGLE_BITS_DEF    = 14;
    localparam int RAW_W             = 16;
    localparam int ELAPSED_W         = 24;
    localparam int POS_W             = 30;
    localparam int MEAN_W            = 31;
    localparam int VEL_W             = 32;
    localparam int TURN_W            = 16;
    localparam int SUMA_W            = 32;
    localparam int SUMT_W            = 32;
    localparam int SF_W              = 9;
    localparam int SPV_W             = 8;
    localparam int CNT_W             = 8;
    localparam int MAC_W             = 64;

    localparam logic [SF_W-1:0]  SF_RESET  = 9'd128;
    localparam logic [SPV_W-1:0] SPV_RESET = 8'd8;
    localparam logic [SF_W-1:0]  SF_MAX    = 9'd256;
    localparam logic [19:0]      US_PER_S  = 20'd1000000;

    localparam logic [0:0] ACT_SAMPLE = 1'b0;
    localparam logic [0:0] ACT_RESET  = 1'b1;

    localparam logic [0:0] REG_SF  = 1'b0;
    localparam logic [0:0] REG_SPV = 1'b1;

    // Divider request / response
    typedef struct packed {
        logic              start;
        logic [MAC_W-1:0]  dividend;   // magnitude
        logic [SUMT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [MAC_W-1:0]  quotient;   // magnitude
    } t_div_rsp;
endpackage
`default_nettype wire

// File: rtl/core/euv_if.sv
// ----------------------------------------------------------------------------
// euv_in_if / euv_out_if
// Valid/ready channels carrying sample items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface euv_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  action;
    logic [15:0] raw_word;
    logic [23:0] elapsed_us;
    modport source (output valid, action, raw_word, elapsed_us, input ready);
    modport sink   (input valid, action, raw_word, elapsed_us, output ready);
endinterface

interface euv_out_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] mean_position;
    logic signed [31:0] smoothed_velocity;
    logic signed [15:0] turns;
    logic               velocity_updated;
    logic               sample_taken;
    modport source (output valid, mean_position, smoothed_velocity, turns,
                    velocity_updated, sample_taken, input ready);
    modport sink   (input valid, mean_position, smoothed_velocity, turns,
                    velocity_updated, sample_taken, output ready);
endinterface
`default_nettype wire

// File: rtl/core/encoder_unwrap_velocity.sv
// Item flow: an ignored or reset item runs UNWRAP, MEAN and OUT; a sample runs
// UNWRAP, STORE, SUM, MEAN and OUT; a sample that closes a velocity window adds
// MULV, DIV (64-step divider) and EMA1..EMA3. MEAN walks the stored positions.
// One item at a time: input is held off until the block is back in IDLE and while
// a result waits.
// Reset (i_rst_n, synchronous): model state cleared (history fill to zero), registers to 128 and 8.
// ----------------------------------------------------------------------------
// encoder_unwrap_velocity
// Multi-turn unwrap, position history mean and smoothed velocity.
// ----------------------------------------------------------------------------
`default_nettype none
module encoder_unwrap_velocity #(
    parameter int HISTORY_DEPTH = euv_pkg::HISTORY_DEPTH_DEF,
    parameter int ANGLE_BITS    = euv_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    euv_in_if.sink           i_in,
    euv_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:2]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW   = $clog2(HISTORY_DEPTH + 1);
    localparam int POSW = ANGLE_BITS + euv_pkg::TURN_W;
    localparam int MW   = euv_pkg::MAC_W;
    localparam int SW   = POSW + 5;   // history sum width
    localparam logic [ANGLE_BITS:0]   FULL = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
    localparam logic [ANGLE_BITS:0]   HALF = (ANGLE_BITS+1)'(1) << (ANGLE_BITS-1);

    typedef enum logic [3:0] {
        S_IDLE, S_UNWRAP, S_STORE, S_SUM, S_MULV, S_DIV, S_EMA1, S_EMA2,
        S_EMA3, S_MEAN, S_OUT
    } t_state;

    t_state r_state;
    // configuration
    logic [euv_pkg::SF_W-1:0]  r_sf;
    logic [euv_pkg::SPV_W-1:0] r_spv;
    // model state
    logic [ANGLE_BITS-1:0]     r_prev;
    logic signed [15:0]        r_turns;
    logic [POSW-1:0]           r_hist [HISTORY_DEPTH];
    logic [HW-1:0]             r_wslot;
    logic [FW-1:0]             r_fill;
    logic [7:0]                r_cnt;
    logic signed [31:0]        r_suma;
    logic [31:0]               r_sumt;
    logic signed [31:0]        r_speed;
    // per-item working registers
    logic [0:0]                r_act;
    logic [ANGLE_BITS-1:0]     r_ang;
    logic [23:0]               r_el;
    logic signed [ANGLE_BITS+1:0] r_step;
    logic [HW-1:0]             r_idx;
    logic signed [SW-1:0]      r_hsum;
    logic signed [MW-1:0]      r_acc;
    logic                      r_neg;
    logic signed [31:0]        r_vel;
    logic signed [MW-1:0]      r_prod;
    logic                      r_vupd, r_taken;
    // output register
    logic                      r_ovalid;
    logic signed [30:0]        r_omean;
    logic [FW:0]               r_qcnt;

    euv_pkg::t_div_req w_dreq;
    euv_pkg::t_div_rsp w_drsp;

    euv_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // APB
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            euv_pkg::REG_SF:  prdata = {23'd0, r_sf};
            default:          prdata = {24'd0, r_spv};
        endcase
    end

    logic [MW-1:0] w_mag;
    assign w_mag = r_acc[MW-1] ? MW'(-r_acc) : MW'(r_acc);

    // divider kick and shared multiply operands
    logic signed [MW-1:0] w_q;
    assign w_q = r_neg ? -$signed(w_drsp.quotient) : $signed(w_drsp.quotient);
    assign w_dreq = '{start: (r_state == S_MULV), dividend: w_mag, divisor: r_sumt};

    logic [8:0] w_a;
    assign w_a = (r_sf > euv_pkg::SF_MAX) ? euv_pkg::SF_MAX : r_sf;

    logic signed [ANGLE_BITS+1:0] w_d;
    assign w_d = $signed({2'b00, r_ang}) - $signed({2'b00, r_prev});

    assign i_in.ready = (r_state == S_IDLE) && !(r_ovalid && !o_out.ready);
    assign o_out.valid             = r_ovalid;
    assign o_out.mean_position     = r_omean;
    assign o_out.smoothed_velocity = r_speed;
    assign o_out.turns             = r_turns;
    assign o_out.velocity_updated  = r_vupd;
    assign o_out.sample_taken      = r_taken;

    // mean divide: restoring, one quotient bit per cycle over sum magnitude
    logic [SW-1:0] w_hmag;
    assign w_hmag = r_hsum[SW-1] ? SW'(-r_hsum) : SW'(r_hsum);
    logic [SW-1:0] r_mq;
    logic [FW:0]   r_mr;
    logic [5:0]    r_mstep;
    logic [FW:0]   w_mshift;
    assign w_mshift = {r_mr[FW-1:0], r_mq[SW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sf     <= euv_pkg::SF_RESET;
            r_spv    <= euv_pkg::SPV_RESET;
            r_prev   <= '0;
            r_turns  <= '0;
            r_wslot  <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_suma   <= '0;
            r_sumt   <= '0;
            r_speed  <= '0;
            r_ovalid <= 1'b0;
            r_vupd   <= 1'b0;
            r_taken  <= 1'b0;
            r_omean  <= '0;
            r_qcnt   <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == euv_pkg::REG_SF) r_sf <= pwdata[8:0];
                else                              r_spv <= pwdata[7:0];
            end
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_act   <= i_in.action;
                        r_ang   <= i_in.raw_word[ANGLE_BITS-1:0];
                        r_el    <= i_in.elapsed_us;
                        r_vupd  <= 1'b0;
                        r_taken <= 1'b0;
                        r_state <= S_UNWRAP;
                    end
                end
                S_UNWRAP: begin
                    if (r_act == euv_pkg::ACT_RESET) begin
                        r_turns <= '0;
                        r_state <= S_MEAN;
                    end else if (r_el == '0) begin
                        r_state <= S_MEAN;
                    end else begin
                        r_taken <= 1'b1;
                        if (w_d > $signed({1'b0, HALF})) begin
                            r_step <= w_d - $signed({1'b0, FULL});
                            if (r_turns != 16'sh8000) r_turns <= r_turns - 1'b1;
                        end else if (w_d < -$signed({1'b0, HALF})) begin
                            r_step <= w_d + $signed({1'b0, FULL});
                            if (r_turns != 16'sh7FFF) r_turns <= r_turns + 1'b1;
                        end else begin
                            r_step <= w_d;
                        end
                        r_prev  <= r_ang;
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_hist[r_wslot] <= POSW'($signed({1'b0, r_ang}))
                                     + (POSW'(r_turns) << ANGLE_BITS);
                    r_wslot <= (r_wslot == HW'(HISTORY_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
                    if (r_fill != FW'(HISTORY_DEPTH)) r_fill <= r_fill + 1'b1;
                    r_suma  <= r_suma + 32'(r_step);
                    r_sumt  <= r_sumt + 32'(r_el);
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_cnt >= r_spv) begin
                        r_cnt  <= '0;
                        r_suma <= '0;
                        // time sum feeds the divider kick, cleared there
                        if (r_sumt != '0) begin
                            r_acc   <= MW'(r_suma) * $signed({1'b0, euv_pkg::US_PER_S});
                            r_neg   <= r_suma[31];
                            r_state <= S_MULV;
                        end else begin
                            r_state <= S_MEAN;
                        end
                    end else begin
                        r_state <= S_MEAN;
                    end
                end
                S_MULV: begin
                    r_sumt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        if (w_q > 64'sh7FFFFFFF)       r_vel <= 32'sh7FFFFFFF;
                        else if (w_q < -64'sh80000000) r_vel <= 32'sh80000000;
                        else                            r_vel <= w_q[31:0];
                        r_state <= S_EMA1;
                    end
                end
                S_EMA1: begin
                    r_prod  <= MW'(r_vel) * $signed({1'b0, w_a});
                    r_state <= S_EMA2;
                end
                S_EMA2: begin
                    r_prod  <= r_prod + MW'(r_speed) * $signed({1'b0, 9'd256 - w_a});
                    r_state <= S_EMA3;
                end
                S_EMA3: begin
                    r_speed <= 32'(r_prod >>> 8);
                    r_vupd  <= 1'b1;
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    // walk the history one entry a cycle, then divide by fill
                    if (r_qcnt == '0) begin
                        r_hsum <= '0;
                        r_idx  <= '0;
                        r_qcnt <= (r_fill == '0) ? (FW+1)'(1) : {1'b0, r_fill} + 1'b1;
                        r_mstep <= '0;
                    end else if (r_qcnt != (FW+1)'(1)) begin
                        r_hsum <= r_hsum + SW'($signed(r_hist[r_idx]));
                        r_idx  <= r_idx + 1'b1;
                        r_qcnt <= r_qcnt - 1'b1;
                    end else begin
                        r_mq    <= w_hmag;
                        r_mr    <= '0;
                        r_mstep <= 6'(SW);
                        r_qcnt  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_mstep != '0) begin
                        r_mq    <= {r_mq[SW-2:0], (w_mshift >= {1'b0, r_fill})};
                        r_mr    <= (w_mshift >= {1'b0, r_fill}) ?
                                   w_mshift - {1'b0, r_fill} : w_mshift;
                        r_mstep <= r_mstep - 1'b1;
                    end else if (!r_ovalid || o_out.ready) begin
                        if (r_fill == '0)     r_omean <= '0;
                        else if (r_hsum[SW-1]) r_omean <= 31'(-$signed(r_mq));
                        else                   r_omean <= 31'(r_mq);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/euv_div.sv
// ----------------------------------------------------------------------------
// euv_div
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module euv_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire euv_pkg::t_div_req i_req,
    output euv_pkg::t_div_rsp      o_rsp
);
    localparam int N  = euv_pkg::MAC_W;
    localparam int D  = euv_pkg::SUMT_W;
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  r_quo, n_quo;
    logic [D:0]    r_rem, n_rem;
    logic [D-1:0]  r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [D:0]    w_shift;

    // one shift-subtract step
    always_comb begin
        w_shift = {r_rem[D-1:0], r_quo[N-1]};
        n_quo   = {r_quo[N-2:0], 1'b0};
        n_rem   = w_shift;
        if (w_shift >= {1'b0, r_dvs}) begin
            n_rem    = w_shift - {1'b0, r_dvs};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, quotient: r_quo};
endmodule
`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for encoder_unwrap_velocity. A table of directed beats
// comes first, then random angle trajectories under several register settings.
// Every result beat is checked against its typed row or a built-in model of the
// unwrap, history and velocity logic; both channels stall at random in most phases.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = euv_pkg::HISTORY_DEPTH_DEF;
    localparam int ANGLE_BITS = euv_pkg::ANGLE_BITS_DEF;
    localparam int FULL_TURN  = 1 << ANGLE_BITS;
    localparam int HALF_TURN  = FULL_TURN / 2;
    localparam int DRAIN_WAIT = 120;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic signed [euv_pkg::MEAN_W-1:0] mean;
        logic signed [euv_pkg::VEL_W-1:0]  vel;
        logic signed [euv_pkg::TURN_W-1:0] turns;
        logic                              upd;
        logic                              taken;
    } t_result;

    typedef struct {
        logic [0:0]                    act;
        logic [euv_pkg::RAW_W-1:0]     raw;
        logic [euv_pkg::ELAPSED_W-1:0] elapsed;
        bit                            typed;
        t_result                       res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:2]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    euv_in_if  in_ch();
    euv_out_if out_ch();

    encoder_unwrap_velocity dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Model state
    logic [euv_pkg::SF_W-1:0]  m_smooth_factor;
    logic [euv_pkg::SPV_W-1:0] m_window;
    logic [ANGLE_BITS-1:0]     m_prev_angle;
    int                        m_turns;
    longint                    m_history [DEPTH];
    int                        m_slot;
    int                        m_fill;
    int                        m_count;
    longint                    m_angle_sum;
    longint                    m_time_sum;
    longint                    m_speed;

    t_result pending_results[$];
    int      errors = 0;
    bit      stalls_on;
    int      idle_cycles = 0;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!stalls_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Unwrap / history / velocity prediction for one accepted beat
    function automatic t_result predict_result(logic [0:0] act,
                                               logic [euv_pkg::RAW_W-1:0] raw,
                                               logic [euv_pkg::ELAPSED_W-1:0] elapsed);
        t_result r;
        longint step, total, v, a;
        int angle;
        r.upd = 1'b0;
        r.taken = 1'b0;
        if (act == euv_pkg::ACT_RESET) begin
            m_turns = 0;
        end else if (elapsed != 0) begin
            angle = raw[ANGLE_BITS-1:0];
            step = longint'(angle) - longint'(m_prev_angle);
            if (step > HALF_TURN) begin
                step -= FULL_TURN;
                if (m_turns > -32768) m_turns--;
            end else if (step < -HALF_TURN) begin
                step += FULL_TURN;
                if (m_turns < 32767) m_turns++;
            end
            m_prev_angle = angle[ANGLE_BITS-1:0];
            m_history[m_slot] = longint'(angle) + longint'(m_turns) * FULL_TURN;
            m_slot = (m_slot + 1) % DEPTH;
            if (m_fill < DEPTH) m_fill++;
            m_angle_sum += step;
            m_time_sum += elapsed;
            m_count = (m_count + 1) & 8'hFF;
            r.taken = 1'b1;
            if (m_count >= m_window) begin
                v = (64'sd1000000 * m_angle_sum) / m_time_sum;
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                a = (m_smooth_factor > euv_pkg::SF_MAX) ? 256 : m_smooth_factor;
                m_speed = (a * v + (256 - a) * m_speed) >>> 8;
                r.upd = 1'b1;
                m_angle_sum = 0;
                m_time_sum = 0;
                m_count = 0;
            end
        end
        total = 0;
        for (int i = 0; i < m_fill; i++) total += m_history[i];
        r.mean = euv_pkg::MEAN_W'((m_fill == 0) ? 0 : total / m_fill);
        r.vel = euv_pkg::VEL_W'(m_speed);
        r.turns = euv_pkg::TURN_W'(m_turns);
        return r;
    endfunction

    // One beat on the sample channel; valid stays high across back-to-back beats
    task automatic send_beat(t_row row);
        int gap;
        t_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= row.act;
        in_ch.raw_word   <= row.raw;
        in_ch.elapsed_us <= row.elapsed;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = predict_result(row.act, row.raw, row.elapsed);
        pending_results.push_back(row.typed ? row.res : predicted);
    endtask

    function automatic t_row plain_row(logic [0:0] act, logic [euv_pkg::RAW_W-1:0] raw,
                                       logic [euv_pkg::ELAPSED_W-1:0] elapsed);
        t_row row;
        row.act = act;
        row.raw = raw;
        row.elapsed = elapsed;
        row.typed = 1'b0;
        row.res = '{default: '0};
        return row;
    endfunction

    task automatic send_sample(logic [0:0] act, logic [euv_pkg::RAW_W-1:0] raw,
                               logic [euv_pkg::ELAPSED_W-1:0] elapsed);
        send_beat(plain_row(act, raw, elapsed));
    endtask

    // Register write: wait for the block to drain, then setup and access phases
    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= idx;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == euv_pkg::REG_SF) m_smooth_factor = value[euv_pkg::SF_W-1:0];
        else                        m_window = value[euv_pkg::SPV_W-1:0];
    endtask

    // Result sink stalls
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            out_ch.ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: mean %0d", out_ch.mean_position);
            end else begin
                e = pending_results.pop_front();
                if (e.mean !== out_ch.mean_position || e.vel !== out_ch.smoothed_velocity ||
                    e.turns !== out_ch.turns || e.upd !== out_ch.velocity_updated ||
                    e.taken !== out_ch.sample_taken) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp mean %0d vel %0d turns %0d upd %b taken %b",
                                  " / got mean %0d vel %0d turns %0d upd %b taken %b"},
                                 e.mean, e.vel, e.turns, e.upd, e.taken,
                                 out_ch.mean_position, out_ch.smoothed_velocity,
                                 out_ch.turns, out_ch.velocity_updated, out_ch.sample_taken);
                end
            end
        end
    end

    // Watchdog on beats of either channel and on APB selects
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_row typed_row(logic [0:0] act, logic [euv_pkg::RAW_W-1:0] raw,
                                       logic [euv_pkg::ELAPSED_W-1:0] elapsed, int mean,
                                       int turns, logic taken);
        t_row row;
        row.act = act;
        row.raw = raw;
        row.elapsed = elapsed;
        row.typed = 1'b1;
        row.res = '{mean: euv_pkg::MEAN_W'(mean), vel: '0,
                    turns: euv_pkg::TURN_W'(turns), upd: 1'b0, taken: taken};
        return row;
    endfunction

    initial begin
        t_row directed[$];
        int angle, step, sf, spv;
        int settings_sf[6];
        int settings_spv[6];

        settings_sf  = '{128, 0, 256, 511, 37, 256};
        settings_spv = '{8, 1, 255, 0, 3, 1};
        i_rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        in_ch.valid <= 1'b0; in_ch.action <= euv_pkg::ACT_SAMPLE;
        in_ch.raw_word <= '0; in_ch.elapsed_us <= '0;
        stalls_on = 1'b1;
        m_smooth_factor = euv_pkg::SF_RESET; m_window = euv_pkg::SPV_RESET;
        m_prev_angle = '0; m_turns = 0; m_slot = 0; m_fill = 0; m_count = 0;
        m_angle_sum = 0; m_time_sum = 0; m_speed = 0;
        foreach (m_history[i]) m_history[i] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero time, reset item, wraps both ways, exact half turn
        directed.push_back(typed_row(euv_pkg::ACT_SAMPLE, 16'h0000, 24'd0, 0, 0, 1'b0));
        directed.push_back(typed_row(euv_pkg::ACT_RESET, 16'hFFFF, 24'hFFFFFF, 0, 0, 1'b0));
        directed.push_back(typed_row(euv_pkg::ACT_SAMPLE, 16'hFFFF, 24'd1, -1, -1, 1'b1));
        directed.push_back(typed_row(euv_pkg::ACT_SAMPLE, 16'h0000, 24'hFFFFFF, 0, 0, 1'b1));
        // exactly half a turn forward, then back with junk high bits
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'h2000, 24'd1000));
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'hC000, 24'd1000));
        // just over half a turn
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'h6001, 24'd1));
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'h3FFF, 24'hFFFFFF));
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'h5555, 24'd0));
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'hAAAA, 24'h800000));
        directed.push_back(plain_row(euv_pkg::ACT_RESET, 16'h0000, 24'd0));
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'h1234, 24'd7));
        // fast reverse then fast forward
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'h0100, 24'd1));
        directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'h2100, 24'd1));
        for (int i = 0; i < 6; i++)
            directed.push_back(plain_row(euv_pkg::ACT_SAMPLE, 16'(i * 3000), 24'd50));
        foreach (directed[i]) send_beat(directed[i]);

        // Random trajectories under several register settings
        angle = 0;
        for (int ph = 0; ph < 6; ph++) begin
            sf = settings_sf[ph];
            spv = settings_spv[ph];
            write_reg(euv_pkg::REG_SF, 32'(sf));
            write_reg(euv_pkg::REG_SPV, 32'(spv));
            stalls_on = (ph != 2);
            for (int n = 0; n < 165; n++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    send_sample(euv_pkg::ACT_RESET, 16'($urandom), 24'($urandom));
                end else if (r < 9) begin
                    send_sample(euv_pkg::ACT_SAMPLE, 16'($urandom), 24'd0);
                end else if (r < 15) begin
                    send_sample(euv_pkg::ACT_SAMPLE, 16'($urandom), 24'($urandom));
                end else begin
                    step = (r < 70) ? $urandom_range(0, 1000) - 500
                                    : $urandom_range(0, 2 * HALF_TURN) - HALF_TURN;
                    angle = (angle + step) & (FULL_TURN - 1);
                    send_sample(euv_pkg::ACT_SAMPLE, {2'($urandom), 14'(angle)},
                                (r < 85) ? 24'($urandom_range(1, 5000))
                                         : 24'($urandom_range(1, 24'hFFFFFF)));
                end
            end
        end

        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: encoder_unwrap_velocity.f
rtl/core/euv_pkg.sv
rtl/core/euv_if.sv
rtl/core/euv_div.sv
rtl/core/encoder_unwrap_velocity.sv
verif/tb.sv
